### rtl/core/mld_pkg.sv
// Shared types and constants for the locator decoder.
// Holds the classified character record and the per-position cell tables.
// No dependencies.
`default_nettype none

package mld_pkg;

  // Character position pairs: field, square, subsquare, extended square.
  localparam logic [1:0] STAGE_FIELD  = 2'd0;
  localparam logic [1:0] STAGE_SQUARE = 2'd1;
  localparam logic [1:0] STAGE_SUBSQ  = 2'd2;
  localparam logic [1:0] STAGE_EXTSQ  = 2'd3;

  // Position count: eight checked characters, then saturation at nine.
  localparam logic [3:0] POS_CHECKED = 4'd8;
  localparam logic [3:0] POS_SAT     = 4'd9;

  // Cell sizes per stage in 1/480 degree units.
  localparam logic [17:0] LON_UNIT [4] = '{18'd9600, 18'd960, 18'd40, 18'd4};
  localparam logic [16:0] LAT_UNIT [4] = '{17'd4800, 17'd480, 17'd20, 17'd2};

  // Offset from the accumulated corner to the cell centre, including the
  // shift from the south-west origin, indexed by the number of pairs less one.
  localparam logic signed [17:0] LON_CTR_OFS [4] = '{
    -18'sd81600, -18'sd85920, -18'sd86380, -18'sd86398};
  localparam logic signed [16:0] LAT_CTR_OFS [4] = '{
    -17'sd40800, -17'sd42960, -17'sd43190, -17'sd43199};

  // One character after classification, independent of its position.
  typedef struct packed {
    logic       blank;   // whitespace, not counted
    logic       digit;   // '0'..'9'
    logic       let_r;   // 'A'..'R' after case folding
    logic       let_x;   // 'A'..'X' after case folding
    logic [4:0] val;     // digit or letter value, meaningful when in class
    logic       last;    // ends the string
  } mld_item_t;

endpackage

`default_nettype wire

### rtl/core/maidenhead_locator_decoder.sv
// Maidenhead locator decoder.
// Input queue side: present one character on in_char_code with in_last_char
// marking the end of the string; a request is taken at an edge with push high
// and full low. Whitespace is skipped and lower case is folded to upper case.
// Result queue side: while empty is low the oldest result is shown on the
// out_ ports (valid flag, cell centre latitude and longitude in 1/480 degree
// units, number of pairs); it is taken at an edge with pop high.
// One request per cycle is sustained while the result side keeps up. The
// last character of a string is written into the classified character
// queue and, once it reaches the head and the result slot is free, loads
// the result register, whose contents show on the out_ ports and can then
// be popped. The back end works on one character per cycle, which sets the
// rate, unless a character that ends a string waits for the result slot.
// When the receiver stalls the result register holds; further characters of
// the next string keep flowing until a character that ends a string reaches
// the back end. That character waits at the head of the queue until the
// result slot frees; the queue fills behind it and full rises.
// Synchronous reset empties both queues and clears the string state.
// Depends on mld_pkg, mld_front, mld_queue and mld_back.
`default_nettype none

module maidenhead_locator_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         in_char_code,
  input  wire logic               in_last_char,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    out_valid_res,
  output logic signed [16:0]      out_latitude,
  output logic signed [17:0]      out_longitude,
  output logic [2:0]              out_precision
);
  import mld_pkg::*;

  mld_item_t front_item;
  mld_item_t q_item;
  logic      q_valid;
  logic      q_take;

  // Classify the character as it arrives.
  mld_front u_front (
    .char_code (in_char_code),
    .last_char (in_last_char),
    .item      (front_item)
  );

  // Decouple classification from the accumulating back end.
  mld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (front_item),
    .full     (full),
    .rd_en    (q_take),
    .rd_data  (q_item),
    .rd_valid (q_valid)
  );

  // Position checks, accumulation and result register.
  mld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item       (q_item),
    .item_take  (q_take),
    .res_empty  (empty),
    .res_pop    (pop),
    .res_valid  (out_valid_res),
    .res_lat    (out_latitude),
    .res_lon    (out_longitude),
    .res_prec   (out_precision)
  );

endmodule

`default_nettype wire

### rtl/core/mld_front.sv
// Front end of the locator decoder: classifies each incoming character.
// Depends on mld_pkg for the classified record type.
`default_nettype none

module mld_front (
  input  wire logic [7:0]       char_code,
  input  wire logic             last_char,
  output mld_pkg::mld_item_t    item
);
  import mld_pkg::*;

  logic [7:0] up_code;
  logic       is_alpha;

  // Fold lower case to upper case; bytes above 127 fall in no class.
  always_comb begin
    if (char_code >= 8'h61 && char_code <= 8'h7A) begin
      up_code = char_code - 8'd32;
    end else begin
      up_code = char_code;
    end
  end

  assign is_alpha = (up_code >= 8'h41);

  // Class flags and value of the character.
  always_comb begin
    item.blank = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
    item.digit = (up_code >= 8'h30) && (up_code <= 8'h39);
    item.let_r = is_alpha && (up_code <= 8'h52);
    item.let_x = is_alpha && (up_code <= 8'h58);
    item.last  = last_char;
    if (item.digit) begin
      item.val = 5'(up_code - 8'h30);
    end else begin
      item.val = 5'(up_code - 8'h41);
    end
  end

endmodule

`default_nettype wire

### rtl/core/mld_queue.sv
// Short queue of classified characters between the front and back ends.
// Depends on mld_pkg for the record type.
`default_nettype none

module mld_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire mld_pkg::mld_item_t wr_data,
  output logic                    full,
  input  wire logic               rd_en,
  output mld_pkg::mld_item_t      rd_data,
  output logic                    rd_valid
);
  import mld_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  mld_item_t         slot_r [DEPTH];
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     cnt_r,  cnt_nxt;
  logic              do_wr, do_rd;

  assign full     = (cnt_r == CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[head_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Pointer and fill count update.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
    end
    if (do_rd) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_wr) begin
      slot_r[tail_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mld_back.sv
// Back end of the locator decoder: position checks, corner accumulation
// and the registered result stage. Depends on mld_pkg for tables and types.
`default_nettype none

module mld_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  input  wire mld_pkg::mld_item_t  item,
  output logic                     item_take,
  output logic                     res_empty,
  input  wire logic                res_pop,
  output logic                     res_valid,
  output logic signed [16:0]       res_lat,
  output logic signed [17:0]       res_lon,
  output logic [2:0]               res_prec
);
  import mld_pkg::*;

  logic [3:0]         pos_r, pos_nxt;
  logic [16:0]        lat_acc_r, lat_acc_nxt;
  logic [17:0]        lon_acc_r, lon_acc_nxt;
  logic               bad_r, bad_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic signed [16:0] out_lat_r, out_lat_nxt;
  logic signed [17:0] out_lon_r, out_lon_nxt;
  logic [2:0]         out_prec_r, out_prec_nxt;

  logic [1:0]         stage;
  logic               class_ok;
  logic               slot_free;
  logic               len_ok;
  logic [1:0]         ctr_idx;
  logic [17:0]        lon_step;
  logic [16:0]        lat_step;

  assign stage     = pos_r[2:1];
  assign slot_free = !out_full_r || res_pop;
  assign item_take = item_valid && (!item.last || slot_free);
  assign lon_step  = 18'(item.val) * LON_UNIT[stage];
  assign lat_step  = 17'(item.val) * LAT_UNIT[stage];

  // Character class required at the current position.
  always_comb begin
    unique case (stage)
      STAGE_FIELD:  class_ok = item.let_r;
      STAGE_SUBSQ:  class_ok = item.let_x;
      STAGE_SQUARE,
      STAGE_EXTSQ:  class_ok = item.digit;
      default:      class_ok = 1'b0;
    endcase
  end

  // Accumulate the corner and track the position for the taken character.
  always_comb begin
    pos_nxt     = pos_r;
    lat_acc_nxt = lat_acc_r;
    lon_acc_nxt = lon_acc_r;
    bad_nxt     = bad_r;
    if (item_take && !item.blank) begin
      if (pos_r < POS_CHECKED) begin
        if (!class_ok) begin
          bad_nxt = 1'b1;
        end else if (!pos_r[0]) begin
          lon_acc_nxt = lon_acc_r + lon_step;
        end else begin
          lat_acc_nxt = lat_acc_r + lat_step;
        end
      end
      if (pos_r < POS_SAT) begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  // Form the result from the updated state when the string ends.
  assign len_ok  = (pos_nxt == 4'd2) || (pos_nxt == 4'd4) ||
                   (pos_nxt == 4'd6) || (pos_nxt == 4'd8);
  assign ctr_idx = pos_nxt[2:1] - 2'd1;

  always_comb begin
    out_full_nxt = out_full_r && !res_pop;
    out_ok_nxt   = out_ok_r;
    out_lat_nxt  = out_lat_r;
    out_lon_nxt  = out_lon_r;
    out_prec_nxt = out_prec_r;
    if (item_take && item.last) begin
      out_full_nxt = 1'b1;
      if (len_ok && !bad_nxt) begin
        out_ok_nxt   = 1'b1;
        out_lat_nxt  = $signed(lat_acc_nxt) + LAT_CTR_OFS[ctr_idx];
        out_lon_nxt  = $signed(lon_acc_nxt) + LON_CTR_OFS[ctr_idx];
        out_prec_nxt = pos_nxt[3:1];
      end else begin
        out_ok_nxt   = 1'b0;
        out_lat_nxt  = '0;
        out_lon_nxt  = '0;
        out_prec_nxt = '0;
      end
    end
  end

  // State and result registers; the string state clears after each result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      lat_acc_r  <= '0;
      lon_acc_r  <= '0;
      bad_r      <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      out_full_r <= out_full_nxt;
      if (item_take && item.last) begin
        pos_r     <= '0;
        lat_acc_r <= '0;
        lon_acc_r <= '0;
        bad_r     <= 1'b0;
      end else begin
        pos_r     <= pos_nxt;
        lat_acc_r <= lat_acc_nxt;
        lon_acc_r <= lon_acc_nxt;
        bad_r     <= bad_nxt;
      end
    end
    out_ok_r   <= out_ok_nxt;
    out_lat_r  <= out_lat_nxt;
    out_lon_r  <= out_lon_nxt;
    out_prec_r <= out_prec_nxt;
  end

  assign res_empty = !out_full_r;
  assign res_valid = out_ok_r;
  assign res_lat   = out_lat_r;
  assign res_lon   = out_lon_r;
  assign res_prec  = out_prec_r;

endmodule

`default_nettype wire

### rtl/core/mld_checker.sv
// Port-level checks for the locator decoder and the bind that attaches them.
// Depends only on the ports of maidenhead_locator_decoder.
`default_nettype none

module mld_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic               out_valid_res,
  input wire logic signed [16:0] out_latitude,
  input wire logic signed [17:0] out_longitude,
  input wire logic [2:0]         out_precision
);

  // Reset leaves the result side empty and the input queue not full.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_valid_res) &&
      $stable(out_latitude) && $stable(out_longitude) && $stable(out_precision)))
    else $error("waiting result changed before it was taken");

  // An invalid result carries zero coordinates and precision.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_valid_res) |->
      (out_latitude == 17'sd0 && out_longitude == 18'sd0 && out_precision == 3'd0))
    else $error("invalid result with nonzero fields");

  // A valid result lies on the globe with one to four pairs.
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_valid_res) |->
      (out_precision >= 3'd1 && out_precision <= 3'd4 &&
       out_latitude > -17'sd43200 && out_latitude < 17'sd43200 &&
       out_longitude > -18'sd86400 && out_longitude < 18'sd86400))
    else $error("valid result out of range");

endmodule

bind maidenhead_locator_decoder mld_checker u_mld_checker (.*);

`default_nettype wire

### tb/sv/mld_locator_scoreboard.sv
`timescale 1ns / 100ps
// Locator scoreboard: predicts the decoder's result for each string and checks
// the results that leave the block. Depends on mld_pkg for the stage codes.

package mld_locator_check_pkg;
  import mld_pkg::*;

  // One decoded locator as it leaves the result side of the block.
  typedef struct packed {
    logic               valid;
    logic signed [16:0] lat;
    logic signed [17:0] lon;
    logic [2:0]         prec;
  } locator_fix_t;

  // Cell sizes and half cells per stage, in 1/480 degree units.
  localparam int LON_CELL [4] = '{9600, 960, 40, 4};
  localparam int LAT_CELL [4] = '{4800, 480, 20, 2};
  localparam int LON_HALF [4] = '{4800, 480, 20, 2};
  localparam int LAT_HALF [4] = '{2400, 240, 10, 1};

  class locator_scoreboard;
    logic [3:0]   char_pos;
    logic [16:0]  lat_acc;
    logic [17:0]  lon_acc;
    logic         bad_char;
    locator_fix_t pending_fixes[$];
    int           errors;

    function new();
      clear_string();
      errors = 0;
    endfunction

    function void clear_string();
      char_pos = '0;
      lat_acc  = '0;
      lon_acc  = '0;
      bad_char = 1'b0;
    endfunction

    function int pending_count();
      return pending_fixes.size();
    endfunction

    // Advance the string state by one accepted request and, on the last
    // character, queue the locator that the block should report.
    function void take_char(logic [7:0] code, logic last);
      logic [7:0]   c;
      logic [1:0]   stage;
      logic [4:0]   val;
      logic         in_class;
      int           pairs;
      int           lat_c;
      int           lon_c;
      locator_fix_t fix;
      c = code;
      if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
        if (c >= "a" && c <= "z") c = c - 8'd32;
        if (char_pos < POS_CHECKED) begin
          stage = char_pos[2:1];
          // Letters at the field and subsquare stages, digits otherwise.
          if (stage == STAGE_FIELD || stage == STAGE_SUBSQ) begin
            in_class = (c >= "A") && (c <= ((stage == STAGE_FIELD) ? "R" : "X"));
            val = 5'(c - "A");
          end else begin
            in_class = (c >= "0") && (c <= "9");
            val = 5'(c - "0");
          end
          if (!in_class) begin
            bad_char = 1'b1;
          end else if (!char_pos[0]) begin
            lon_acc = 18'(int'(lon_acc) + int'(val) * LON_CELL[stage]);
          end else begin
            lat_acc = 17'(int'(lat_acc) + int'(val) * LAT_CELL[stage]);
          end
        end
        if (char_pos < POS_SAT) char_pos = char_pos + 4'd1;
      end
      if (last) begin
        fix = '0;
        // Only an even count from two to eight with no bad character decodes.
        if (!bad_char && !char_pos[0] && char_pos != 0 && char_pos <= POS_CHECKED) begin
          pairs     = int'(char_pos) / 2;
          lat_c     = int'(lat_acc) - 43200 + LAT_HALF[pairs - 1];
          lon_c     = int'(lon_acc) - 86400 + LON_HALF[pairs - 1];
          fix.valid = 1'b1;
          fix.lat   = 17'(lat_c);
          fix.lon   = 18'(lon_c);
          fix.prec  = 3'(pairs);
        end
        pending_fixes = {pending_fixes, fix};
        clear_string();
      end
    endfunction

    // Compare one accepted result with the oldest predicted locator.
    function void check_fix(locator_fix_t got);
      locator_fix_t want;
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected result valid_res=%0d lat=%0d lon=%0d prec=%0d",
                 $time, got.valid, got.lat, got.lon, got.prec);
        errors++;
        return;
      end
      want = pending_fixes.pop_front();
      if (got.valid !== want.valid || got.lat !== want.lat ||
          got.lon !== want.lon || got.prec !== want.prec) begin
        $display("%0t: mismatch expected valid_res=%0d lat=%0d lon=%0d prec=%0d",
                 $time, want.valid, want.lat, want.lon, want.prec);
        $display("%0t:          actual   valid_res=%0d lat=%0d lon=%0d prec=%0d",
                 $time, got.valid, got.lat, got.lon, got.prec);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/sv/maidenhead_locator_decoder_test.sv
`timescale 1ns / 100ps
// Top-level testbench for the locator decoder: sends directed and random
// locator strings and checks every result. Depends on mld_pkg, the RTL and
// mld_locator_check_pkg.

module maidenhead_locator_decoder_test;
  import mld_pkg::*;
  import mld_locator_check_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_CHARS = 1430;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         in_char_code;
  logic               in_last_char;
  logic               empty;
  logic               pop;
  logic               out_valid_res;
  logic signed [16:0] out_latitude;
  logic signed [17:0] out_longitude;
  logic [2:0]         out_precision;

  locator_scoreboard board = new();
  logic [7:0]        text[$];
  int                chars_sent;
  int                snd_idle_pct;
  int                rcv_idle_pct;
  int                stall_cycles;

  maidenhead_locator_decoder u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_char_code  (in_char_code),
    .in_last_char  (in_last_char),
    .empty         (empty),
    .pop           (pop),
    .out_valid_res (out_valid_res),
    .out_latitude  (out_latitude),
    .out_longitude (out_longitude),
    .out_precision (out_precision)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one character, idling first at random, and wait until it is taken.
  task automatic put_char(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    board.take_char(c, last);
    chars_sent++;
  endtask

  // Send the buffered string, marking its final character as the last one.
  task automatic send_text();
    foreach (text[i]) put_char(text[i], i == text.size() - 1);
  endtask

  function automatic void load_text(string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text = {text, s[i]};
  endfunction

  function automatic logic [7:0] locator_letter(int span);
    logic [7:0] c;
    c = 8'("A" + $urandom_range(0, span - 1));
    if ($urandom_range(0, 1)) c = c + 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'(9 + r);
  endfunction

  // Mostly well-formed locators with random content, some broken, some noise.
  task automatic send_random_string();
    int kind;
    int pairs;
    kind = $urandom_range(0, 99);
    text.delete();
    if (kind < 87) begin
      pairs = $urandom_range(1, 4);
      for (int k = 0; k < 2 * pairs; k++) begin
        if ($urandom_range(0, 9) == 0) text = {text, blank_char()};
        case (2'(k / 2))
          STAGE_FIELD: text = {text, locator_letter(18)};
          STAGE_SUBSQ: text = {text, locator_letter(24)};
          default:     text = {text, 8'("0" + $urandom_range(0, 9))};
        endcase
      end
      // Break the string by a stray byte, a dropped character or extra ones.
      if (kind >= 72) begin
        case ($urandom_range(0, 2))
          0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
          1: void'(text.pop_back());
          default: repeat ($urandom_range(1, 4)) text = {text, 8'($urandom_range(0, 255))};
        endcase
      end
      if ($urandom_range(0, 6) == 0) text = {text, blank_char()};
    end else begin
      repeat ($urandom_range(1, 12)) text = {text, 8'($urandom_range(0, 255))};
    end
    if (text.size() == 0) text = {text, blank_char()};
    send_text();
  endtask

  // Result side: take a result whenever pop meets a non-empty queue.
  initial begin
    locator_fix_t seen;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        seen.valid = out_valid_res;
        seen.lat   = out_latitude;
        seen.lon   = out_longitude;
        seen.prec  = out_precision;
        board.check_fix(seen);
      end
      pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Watchdog: give up when no request moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_char_code <= '0;
    in_last_char <= 1'b0;
    chars_sent   = 0;
    snd_idle_pct = 36;
    rcv_idle_pct = 83;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: both corners of the grid, case folding, a blank that
    // ends the string, a blank-only string, a high byte, a digit in the field
    // pair and an odd length.
    load_text("AA00AA00");
    send_text();
    load_text("rr99xx99");
    send_text();
    load_text("JO ");
    send_text();
    text.delete();
    text = {text, 8'h0D};
    send_text();
    text.delete();
    text = {text, 8'hFF};
    send_text();
    load_text("A0");
    send_text();
    load_text("jo6");
    send_text();

    // Random strings in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 83 : 0;
      rcv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 36 : 0;
      while (chars_sent < 23 + (phase + 1) * RANDOM_CHARS / 3) send_random_string();
    end
    push <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### maidenhead_locator_decoder.f
rtl/core/mld_pkg.sv
rtl/core/mld_front.sv
rtl/core/mld_queue.sv
rtl/core/mld_back.sv
rtl/core/maidenhead_locator_decoder.sv
rtl/core/mld_checker.sv
tb/sv/mld_locator_scoreboard.sv
tb/sv/maidenhead_locator_decoder_test.sv
